// File: hw/rtl/rcrd_pkg.sv
// Shared types and constants for the remote control report deframer.
package rcrd_pkg;

  // Framing constants.
  localparam logic [7:0] SYNC_BYTE     = 8'h55;
  localparam logic [9:0] MIN_LENGTH    = 10'd13;
  localparam logic [9:0] REPORT_LENGTH = 10'd58;
  localparam logic [9:0] REPORT_FIRST  = 10'd16;
  localparam logic [9:0] BODY_START    = 10'd3;
  localparam int         REPORT_BYTES  = 14;

  // Positions inside the captured report window (frame offset minus 16).
  localparam int IDX_RIGHT_V  = 0;
  localparam int IDX_RIGHT_H  = 2;
  localparam int IDX_LEFT_V   = 4;
  localparam int IDX_LEFT_H   = 6;
  localparam int IDX_CAMERA   = 8;
  localparam int IDX_WHEEL    = 10;
  localparam int IDX_MODE     = 12;
  localparam int IDX_SWITCHES = 13;

  // Axis limits and mode thresholds.
  localparam logic [14:0] AXIS_MAX  = 15'd32767;
  localparam logic [14:0] AXIS_MID  = 15'd16384;
  localparam logic [14:0] AXIS_ZERO = 15'd0;
  localparam logic [7:0]  MODE_HIGH = 8'd32;
  localparam logic [7:0]  MODE_MID  = 8'd16;

  // Register reset values.
  localparam logic [11:0] STICK_OFFSET_RST = 12'd750;
  localparam logic [5:0]  STICK_GAIN_RST   = 6'd12;
  localparam logic [5:0]  CAMERA_GAIN_RST  = 6'd8;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_STICK_OFFSET = 2'd0,
    REG_STICK_GAIN   = 2'd1,
    REG_CAMERA_GAIN  = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // The fourteen report bytes of one frame.
  typedef logic [REPORT_BYTES-1:0][7:0] report_bytes_t;

  // Queue status as seen by the back part.
  typedef struct packed {
    logic          valid;
    report_bytes_t bytes;
  } queue_head_t;

endpackage

// File: hw/rtl/rcrd_front.sv
// Front part: hunts for the sync byte, checks the length and captures report bytes.
module rcrd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output rcrd_pkg::report_bytes_t q_bytes
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_LEN_HI = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              hdr0_r, hdr0_nxt;
  logic [9:0]              frame_len_r, frame_len_nxt;
  logic [9:0]              byte_cnt_r, byte_cnt_nxt;
  rcrd_pkg::report_bytes_t rpt_r;
  logic [9:0]              cnt_inc;
  logic [9:0]              len;
  logic [9:0]              win_idx;
  logic                    last_byte;
  logic                    is_report;
  logic                    accept;

  // The last byte of a report frame needs a free queue slot.
  assign cnt_inc   = byte_cnt_r + 10'd1;
  assign last_byte = (cnt_inc == frame_len_r);
  assign is_report = (frame_len_r == rcrd_pkg::REPORT_LENGTH);
  assign in_stall  = (phase_r == PH_BODY) && last_byte && is_report && q_full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept && (phase_r == PH_BODY) && last_byte && is_report;
  assign q_bytes   = rpt_r;
  assign len       = {in_rx_byte[1:0], hdr0_r};
  assign win_idx   = byte_cnt_r - rcrd_pkg::REPORT_FIRST;

  // Parser next state.
  always_comb begin
    phase_nxt     = phase_r;
    hdr0_nxt      = hdr0_r;
    frame_len_nxt = frame_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == rcrd_pkg::SYNC_BYTE) phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          hdr0_nxt  = in_rx_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len < rcrd_pkg::MIN_LENGTH) begin
            // Drop the sync byte and search the two header bytes again.
            if (hdr0_r == rcrd_pkg::SYNC_BYTE) begin
              hdr0_nxt  = in_rx_byte;
              phase_nxt = PH_LEN_HI;
            end else if (in_rx_byte == rcrd_pkg::SYNC_BYTE) begin
              phase_nxt = PH_LEN_LO;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end else begin
            frame_len_nxt = len;
            byte_cnt_nxt  = rcrd_pkg::BODY_START;
            phase_nxt     = PH_BODY;
          end
        end
        PH_BODY: begin
          byte_cnt_nxt = cnt_inc;
          if (last_byte) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hdr0_r      <= '0;
      frame_len_r <= '0;
      byte_cnt_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr0_r      <= hdr0_nxt;
      frame_len_r <= frame_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

  // Capture the report window, frame bytes 16 to 29.
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_BODY) && (byte_cnt_r >= rcrd_pkg::REPORT_FIRST) &&
        (win_idx < 10'(rcrd_pkg::REPORT_BYTES))) begin
      rpt_r[win_idx[3:0]] <= in_rx_byte;
    end
  end

endmodule

// File: hw/rtl/rcrd_queue.sv
// Short queue of captured reports between the front and back parts.
module rcrd_queue #(
  parameter int Depth = rcrd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rcrd_pkg::report_bytes_t push_bytes,
  output logic                    full,
  input  logic                    pop,
  output rcrd_pkg::queue_head_t   head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rcrd_pkg::report_bytes_t mem [Depth];
  logic [PtrW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]         count_r, count_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign full       = (count_r == CntFull);
  assign do_push    = push && !full;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.bytes = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage for queued reports.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_bytes;
  end

endmodule

// File: hw/rtl/rcrd_back.sv
// Back part: scales the axes over a shared multiplier and presents the report.
module rcrd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rcrd_pkg::queue_head_t head,
  output logic                  pop,
  input  logic [11:0]           stick_offset,
  input  logic [5:0]            stick_gain,
  input  logic [5:0]            camera_gain,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [14:0]           out_left_horizontal,
  output logic [14:0]           out_left_vertical,
  output logic [14:0]           out_right_horizontal,
  output logic [14:0]           out_right_vertical,
  output logic [14:0]           out_camera_axis,
  output logic [14:0]           out_mode_axis,
  output logic [8:0]            out_button_bits
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam int          NumAxes  = 5;
  localparam logic [2:0]  StepLast = 3'(NumAxes - 1);

  state_t                  state_r, state_nxt;
  logic [2:0]              step_r, step_nxt;
  rcrd_pkg::report_bytes_t work_r;
  logic [14:0]             axis_r [NumAxes];
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              prev_wheel_r;
  logic                    wheel_seen_r;
  logic                    transfer;
  logic signed [15:0]      raw;
  logic signed [16:0]      op_a;
  logic signed [6:0]       op_gain;
  logic signed [23:0]      prod;
  logic [14:0]             clamped;
  logic [7:0]              wheel;
  logic [7:0]              mode;
  logic [7:0]              wheel_diff;
  logic [14:0]             mode_val;
  logic                    wheel_up;
  logic                    wheel_down;

  // Operand selection for the axis in this step.
  always_comb begin
    raw     = $signed({work_r[rcrd_pkg::IDX_LEFT_H+1], work_r[rcrd_pkg::IDX_LEFT_H]});
    op_gain = $signed({1'b0, stick_gain});
    case (step_r)
      3'd0: raw = $signed({work_r[rcrd_pkg::IDX_LEFT_H+1], work_r[rcrd_pkg::IDX_LEFT_H]});
      3'd1: raw = $signed({work_r[rcrd_pkg::IDX_LEFT_V+1], work_r[rcrd_pkg::IDX_LEFT_V]});
      3'd2: raw = $signed({work_r[rcrd_pkg::IDX_RIGHT_H+1], work_r[rcrd_pkg::IDX_RIGHT_H]});
      3'd3: raw = $signed({work_r[rcrd_pkg::IDX_RIGHT_V+1], work_r[rcrd_pkg::IDX_RIGHT_V]});
      default: begin
        raw     = $signed({work_r[rcrd_pkg::IDX_CAMERA+1], work_r[rcrd_pkg::IDX_CAMERA]});
        op_gain = $signed({1'b0, camera_gain});
      end
    endcase
    if (step_r == StepLast) op_a = {raw[15], raw};
    else op_a = {raw[15], raw} - $signed({5'b0, stick_offset});
  end

  // Shared multiplier with clamp to the axis range.
  always_comb begin
    prod = op_a * op_gain;
    if (prod[23]) clamped = rcrd_pkg::AXIS_ZERO;
    else if (prod > 24'sd32767) clamped = rcrd_pkg::AXIS_MAX;
    else clamped = prod[14:0];
  end

  // Mode level and wheel direction.
  always_comb begin
    wheel      = work_r[rcrd_pkg::IDX_WHEEL];
    mode       = work_r[rcrd_pkg::IDX_MODE];
    wheel_diff = wheel - prev_wheel_r;
    wheel_up   = wheel_seen_r && (wheel_diff != 8'd0) && !wheel_diff[7];
    wheel_down = wheel_seen_r && wheel_diff[7];
    if (mode >= rcrd_pkg::MODE_HIGH) mode_val = rcrd_pkg::AXIS_MAX;
    else if (mode >= rcrd_pkg::MODE_MID) mode_val = rcrd_pkg::AXIS_MID;
    else mode_val = rcrd_pkg::AXIS_ZERO;
  end

  // Sequencer: load, five multiply steps, hand over to the output register.
  assign transfer = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign pop      = (state_r == ST_IDLE) && head.valid;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 3'd1;
        if (step_r == StepLast) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (transfer) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      prev_wheel_r <= '0;
      wheel_seen_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (transfer) begin
        prev_wheel_r <= wheel;
        wheel_seen_r <= 1'b1;
      end
    end
  end

  // Working copy and scaled axes.
  always_ff @(posedge clk) begin
    if (pop) work_r <= head.bytes;
    if (state_r == ST_CALC) axis_r[step_r] <= clamped;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (transfer) begin
      out_left_horizontal  <= axis_r[0];
      out_left_vertical    <= axis_r[1];
      out_right_horizontal <= axis_r[2];
      out_right_vertical   <= axis_r[3];
      out_camera_axis      <= axis_r[4];
      out_mode_axis        <= mode_val;
      out_button_bits      <= {wheel_down, wheel_up, work_r[rcrd_pkg::IDX_SWITCHES][7:1]};
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/remote_control_report_deframer.sv
// Top level of the remote control report deframer with its register port.
//
//  Channel | Ports                         | Moves
//  --------+-------------------------------+---------------------------------
//  in      | in_valid, in_stall, in_rx_byte | one received byte per request
//  out     | out_valid, out_stall, out_*   | one decoded report per request
//  cfg     | psel, penable, pwrite, paddr, | stick offset, stick gain and
//          | pwdata, prdata, pready        | camera gain registers
//
// The front takes one byte every cycle while it does not stall; a report frame is 58 bytes long.
// The back handles a report by load, the five steps of its shared multiplier and
// hand-over, and works while the front goes on.
// Reset is synchronous and active low; it returns the parser to sync hunting.
// The input stalls only on the last byte of a report while the queue is full.
module remote_control_report_deframer #(
  parameter int QueueDepth = rcrd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_left_horizontal,
  output logic [14:0] out_left_vertical,
  output logic [14:0] out_right_horizontal,
  output logic [14:0] out_right_vertical,
  output logic [14:0] out_camera_axis,
  output logic [14:0] out_mode_axis,
  output logic [8:0]  out_button_bits,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0]             stick_offset_r;
  logic [5:0]              stick_gain_r;
  logic [5:0]              camera_gain_r;
  logic                    cfg_write;
  rcrd_pkg::reg_idx_t      reg_idx;
  logic                    q_full;
  logic                    q_push;
  logic                    q_pop;
  rcrd_pkg::report_bytes_t q_bytes;
  rcrd_pkg::queue_head_t   q_head;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = rcrd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_offset_r <= rcrd_pkg::STICK_OFFSET_RST;
      stick_gain_r   <= rcrd_pkg::STICK_GAIN_RST;
      camera_gain_r  <= rcrd_pkg::CAMERA_GAIN_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        rcrd_pkg::REG_STICK_OFFSET: stick_offset_r <= pwdata[11:0];
        rcrd_pkg::REG_STICK_GAIN:   stick_gain_r   <= pwdata[5:0];
        rcrd_pkg::REG_CAMERA_GAIN:  camera_gain_r  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      rcrd_pkg::REG_STICK_OFFSET: prdata = {20'b0, stick_offset_r};
      rcrd_pkg::REG_STICK_GAIN:   prdata = {26'b0, stick_gain_r};
      rcrd_pkg::REG_CAMERA_GAIN:  prdata = {26'b0, camera_gain_r};
      default:                    prdata = '0;
    endcase
  end

  rcrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_bytes    (q_bytes)
  );

  rcrd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_bytes (q_bytes),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  rcrd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (q_head),
    .pop                  (q_pop),
    .stick_offset         (stick_offset_r),
    .stick_gain           (stick_gain_r),
    .camera_gain          (camera_gain_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_horizontal  (out_left_horizontal),
    .out_left_vertical    (out_left_vertical),
    .out_right_horizontal (out_right_horizontal),
    .out_right_vertical   (out_right_vertical),
    .out_camera_axis      (out_camera_axis),
    .out_mode_axis        (out_mode_axis),
    .out_button_bits      (out_button_bits)
  );

endmodule

// File: sim/tb_remote_control_report_deframer.sv
// Testbench for the remote control report deframer: byte stream in, decoded reports checked.
`timescale 1ns / 100ps

module tb_remote_control_report_deframer;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 32;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASE_BYTES = 300;
  localparam int PHASE_REPORTS = 4;
  localparam logic [9:0] MAX_FRAME_LENGTH = 10'd1023;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } parse_phase_t;

  typedef struct packed {
    logic [14:0] left_h;
    logic [14:0] left_v;
    logic [14:0] right_h;
    logic [14:0] right_v;
    logic [14:0] camera;
    logic [14:0] mode;
    logic [8:0]  buttons;
  } report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_left_horizontal;
  logic [14:0] out_left_vertical;
  logic [14:0] out_right_horizontal;
  logic [14:0] out_right_vertical;
  logic [14:0] out_camera_axis;
  logic [14:0] out_mode_axis;
  logic [8:0]  out_button_bits;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Decoded reports still owed by the block, oldest first.
  report_t expected_reports[$];
  int error_count = 0;
  int bytes_sent = 0;
  int reports_due = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Predictor state and its copy of the registers.
  parse_phase_t            phase_m;
  logic [7:0]              hdr_lo;
  logic [7:0]              hdr_hi;
  logic [9:0]              frame_len;
  logic [9:0]              byte_cnt;
  rcrd_pkg::report_bytes_t window;
  logic [7:0]              last_wheel;
  logic                    wheel_valid;
  logic [11:0]             stick_offset_cfg;
  logic [5:0]              stick_gain_cfg;
  logic [5:0]              camera_gain_cfg;

  remote_control_report_deframer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_horizontal  (out_left_horizontal),
    .out_left_vertical    (out_left_vertical),
    .out_right_horizontal (out_right_horizontal),
    .out_right_vertical   (out_right_vertical),
    .out_camera_axis      (out_camera_axis),
    .out_mode_axis        (out_mode_axis),
    .out_button_bits      (out_button_bits),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb_remote_control_report_deframer NOT OK");
    $finish;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic void reset_model();
    phase_m = PH_HUNT;
    hdr_lo = 8'd0;
    hdr_hi = 8'd0;
    frame_len = 10'd0;
    byte_cnt = 10'd0;
    window = '0;
    last_wheel = 8'd0;
    wheel_valid = 1'b0;
    stick_offset_cfg = rcrd_pkg::STICK_OFFSET_RST;
    stick_gain_cfg = rcrd_pkg::STICK_GAIN_RST;
    camera_gain_cfg = rcrd_pkg::CAMERA_GAIN_RST;
  endfunction

  // Sync search and the first length byte.
  function automatic void hunt_for_header(input logic [7:0] b);
    if (phase_m == PH_HUNT) begin
      if (b == rcrd_pkg::SYNC_BYTE) phase_m = PH_LEN_LO;
    end else if (phase_m == PH_LEN_LO) begin
      hdr_lo = b;
      phase_m = PH_LEN_HI;
    end
  endfunction

  function automatic logic [14:0] clamp_axis(input int v);
    if (v < 0) return rcrd_pkg::AXIS_ZERO;
    if (v > int'(rcrd_pkg::AXIS_MAX)) return rcrd_pkg::AXIS_MAX;
    return v[14:0];
  endfunction

  // Little-endian signed 16-bit value from the report window.
  function automatic int signed16(input rcrd_pkg::report_bytes_t w, input int idx);
    logic [15:0] raw;
    raw = {w[idx + 1], w[idx]};
    return int'($signed(raw));
  endfunction

  function automatic logic [14:0] scale_stick(input int raw);
    return clamp_axis((raw - int'(stick_offset_cfg)) * int'(stick_gain_cfg));
  endfunction

  // Turns the captured window into one report and updates the wheel history.
  function automatic report_t decode_report();
    report_t r;
    logic [7:0] wheel_step;
    r.left_h = scale_stick(signed16(window, rcrd_pkg::IDX_LEFT_H));
    r.left_v = scale_stick(signed16(window, rcrd_pkg::IDX_LEFT_V));
    r.right_h = scale_stick(signed16(window, rcrd_pkg::IDX_RIGHT_H));
    r.right_v = scale_stick(signed16(window, rcrd_pkg::IDX_RIGHT_V));
    r.camera = clamp_axis(signed16(window, rcrd_pkg::IDX_CAMERA) * int'(camera_gain_cfg));
    if (window[rcrd_pkg::IDX_MODE] >= rcrd_pkg::MODE_HIGH) r.mode = rcrd_pkg::AXIS_MAX;
    else if (window[rcrd_pkg::IDX_MODE] >= rcrd_pkg::MODE_MID) r.mode = rcrd_pkg::AXIS_MID;
    else r.mode = rcrd_pkg::AXIS_ZERO;
    r.buttons = {2'b00, window[rcrd_pkg::IDX_SWITCHES][7:1]};
    if (wheel_valid) begin
      wheel_step = window[rcrd_pkg::IDX_WHEEL] - last_wheel;
      if (wheel_step != 8'd0 && !wheel_step[7]) r.buttons[7] = 1'b1;
      if (wheel_step[7]) r.buttons[8] = 1'b1;
    end
    last_wheel = window[rcrd_pkg::IDX_WHEEL];
    wheel_valid = 1'b1;
    return r;
  endfunction

  // Advances the deframer by one byte; returns 1 when a report falls due.
  function automatic bit deframe_byte(input logic [7:0] b, output report_t rep);
    logic [9:0] len;
    rep = '0;
    deframe_byte = 1'b0;
    case (phase_m) inside
      PH_HUNT, PH_LEN_LO: begin
        hunt_for_header(b);
      end
      PH_LEN_HI: begin
        hdr_hi = b;
        len = {hdr_hi[1:0], hdr_lo};
        if (len < rcrd_pkg::MIN_LENGTH) begin
          // Drop only the sync byte and search the two header bytes again.
          phase_m = PH_HUNT;
          hunt_for_header(hdr_lo);
          hunt_for_header(hdr_hi);
        end else begin
          frame_len = len;
          byte_cnt = rcrd_pkg::BODY_START;
          phase_m = PH_BODY;
        end
      end
      default: begin
        if (byte_cnt >= rcrd_pkg::REPORT_FIRST &&
            byte_cnt < rcrd_pkg::REPORT_FIRST + 10'(rcrd_pkg::REPORT_BYTES))
          window[byte_cnt - rcrd_pkg::REPORT_FIRST] = b;
        byte_cnt = byte_cnt + 10'd1;
        if (byte_cnt == frame_len) begin
          phase_m = PH_HUNT;
          if (frame_len == rcrd_pkg::REPORT_LENGTH) begin
            rep = decode_report();
            deframe_byte = 1'b1;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      error_count += 1;
    end
  endfunction

  // Every report the block hands over is matched against the oldest expectation.
  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report expected none, actual lh=%0d lv=%0d rh=%0d rv=%0d btn=%0h",
                 $time, out_left_horizontal, out_left_vertical, out_right_horizontal,
                 out_right_vertical, out_button_bits);
        error_count += 1;
      end else begin
        want = expected_reports.pop_front();
        check_field("left_horizontal", int'(want.left_h), int'(out_left_horizontal));
        check_field("left_vertical", int'(want.left_v), int'(out_left_vertical));
        check_field("right_horizontal", int'(want.right_h), int'(out_right_horizontal));
        check_field("right_vertical", int'(want.right_v), int'(out_right_vertical));
        check_field("camera_axis", int'(want.camera), int'(out_camera_axis));
        check_field("mode_axis", int'(want.mode), int'(out_mode_axis));
        check_field("button_bits", int'(want.buttons), int'(out_button_bits));
      end
    end
  end

  // Offers one byte as a request, holds it until taken and predicts its effect.
  task automatic send_byte(input logic [7:0] b);
    report_t rep;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent += 1;
    if (deframe_byte(b, rep)) begin
      expected_reports.push_back(rep);
      reports_due += 1;
    end
  endtask

  // A whole frame: sync, two length bytes, then the body with the report window.
  task automatic send_frame(input logic [9:0] len, input rcrd_pkg::report_bytes_t w,
                            input logic [5:0] hi_bits);
    int i;
    send_byte(rcrd_pkg::SYNC_BYTE);
    send_byte(len[7:0]);
    send_byte({hi_bits, len[9:8]});
    for (i = int'(rcrd_pkg::BODY_START); i < int'(len); i++) begin
      if (i >= int'(rcrd_pkg::REPORT_FIRST) &&
          i < int'(rcrd_pkg::REPORT_FIRST) + rcrd_pkg::REPORT_BYTES)
        send_byte(w[i - int'(rcrd_pkg::REPORT_FIRST)]);
      else send_byte(8'($urandom));
    end
  endtask

  // A sync byte followed by a length below the minimum.
  task automatic send_bad_header(input logic [7:0] len_lo, input logic [5:0] hi_bits);
    send_byte(rcrd_pkg::SYNC_BYTE);
    send_byte(len_lo);
    send_byte({hi_bits, 2'b00});
  endtask

  // Stops sending until every owed report has arrived, then lets the block settle.
  task automatic wait_reports_drained(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input rcrd_pkg::reg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in the predictor and reads it back unless it is the unused one.
  task automatic write_reg(input rcrd_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] kept;
    logic [31:0] readback;
    apb_access(1'b1, idx, value, readback);
    case (idx)
      rcrd_pkg::REG_STICK_OFFSET: begin
        stick_offset_cfg = value[11:0];
        kept = {20'd0, value[11:0]};
      end
      rcrd_pkg::REG_STICK_GAIN: begin
        stick_gain_cfg = value[5:0];
        kept = {26'd0, value[5:0]};
      end
      rcrd_pkg::REG_CAMERA_GAIN: begin
        camera_gain_cfg = value[5:0];
        kept = {26'd0, value[5:0]};
      end
      default: begin
        kept = 32'd0;
      end
    endcase
    if (idx != rcrd_pkg::REG_UNUSED) begin
      apb_access(1'b0, idx, 32'd0, readback);
      if (readback !== kept) begin
        $display("%0t: register %s expected %0h, actual %0h", $time, idx.name(), kept,
                 readback);
        error_count += 1;
      end
    end
  endtask

  function automatic rcrd_pkg::report_bytes_t make_window(
      input logic [15:0] rv, input logic [15:0] rh, input logic [15:0] lv,
      input logic [15:0] lh, input logic [15:0] cam, input logic [7:0] wheel,
      input logic [7:0] mode, input logic [7:0] switches);
    rcrd_pkg::report_bytes_t w;
    {w[rcrd_pkg::IDX_RIGHT_V + 1], w[rcrd_pkg::IDX_RIGHT_V]} = rv;
    {w[rcrd_pkg::IDX_RIGHT_H + 1], w[rcrd_pkg::IDX_RIGHT_H]} = rh;
    {w[rcrd_pkg::IDX_LEFT_V + 1], w[rcrd_pkg::IDX_LEFT_V]} = lv;
    {w[rcrd_pkg::IDX_LEFT_H + 1], w[rcrd_pkg::IDX_LEFT_H]} = lh;
    {w[rcrd_pkg::IDX_CAMERA + 1], w[rcrd_pkg::IDX_CAMERA]} = cam;
    w[rcrd_pkg::IDX_WHEEL] = wheel;
    w[rcrd_pkg::IDX_WHEEL + 1] = 8'($urandom);
    w[rcrd_pkg::IDX_MODE] = mode;
    w[rcrd_pkg::IDX_SWITCHES] = switches;
    return w;
  endfunction

  // Stick values aimed at the offset, the clamp limit and negative values.
  function automatic logic [15:0] pick_stick();
    int v;
    int g;
    g = int'(stick_gain_cfg);
    case ($urandom_range(0, 4))
      0: v = int'($urandom);
      1: v = int'(stick_offset_cfg) + int'($urandom_range(0, 8)) - 4;
      2: v = int'(stick_offset_cfg) + ((g != 0) ? 32767 / g : 0) + int'($urandom_range(0, 4)) - 2;
      3: v = int'($urandom_range(0, 4095));
      default: v = 32768 + int'($urandom_range(0, 32767));
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_camera();
    int v;
    int g;
    g = int'(camera_gain_cfg);
    case ($urandom_range(0, 3))
      0: v = int'($urandom);
      1: v = ((g != 0) ? 32767 / g : 0) + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom_range(0, 300));
      default: v = 32768 + int'($urandom_range(0, 32767));
    endcase
    return v[15:0];
  endfunction

  // Report window with the wheel moved by none, one, or across the sign boundary.
  function automatic rcrd_pkg::report_bytes_t random_window();
    logic [7:0] wheel_step;
    logic [7:0] mode;
    case ($urandom_range(0, 5))
      0: wheel_step = 8'h00;
      1: wheel_step = 8'h01;
      2: wheel_step = 8'hFF;
      3: wheel_step = 8'h7F;
      4: wheel_step = 8'h80;
      default: wheel_step = 8'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) mode = 8'($urandom);
    else mode = 8'($urandom_range(12, 36));
    return make_window(pick_stick(), pick_stick(), pick_stick(), pick_stick(), pick_camera(),
                       last_wheel + wheel_step, mode, 8'($urandom));
  endfunction

  // First report without wheel flags, then axis extremes, mode thresholds and wheel moves.
  task automatic test_first_reports();
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0,
                                                    8'd0, 8'd0), 6'd0);
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                                    16'h7FFF, 8'd0, 8'd16, 8'hFF), 6'h3F);
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                                    16'h8000, 8'd1, 8'd32, 8'h00), 6'd0);
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'd750, 16'd751, 16'd3480, 16'd3481,
                                                    16'd4095, 8'd0, 8'd15, 8'hAA), 6'h15);
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'd749, 16'd0, 16'hFFFF, 16'd4096,
                                                    16'd4096, 8'h7F, 8'd31, 8'h55), 6'h2A);
    send_frame(rcrd_pkg::REPORT_LENGTH, make_window(16'd752, 16'd2000, 16'd1, 16'h7FFE,
                                                    16'd1, 8'hFF, 8'd255, 8'h01), 6'd0);
    wait_reports_drained(SETTLE_CYCLES);
  endtask

  // Short lengths drop the sync byte; the stream must recover on the next frame.
  task automatic test_bad_headers();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_bad_header(8'd0, 6'd0);
    send_bad_header(8'd12, 6'h3F);
    send_bad_header(8'd1, 6'h15);
    send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'd0);
    send_bad_header(8'd12, 6'd0);
    send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'h3F);
    wait_reports_drained(SETTLE_CYCLES);
  endtask

  // Frames of other lengths pass through silently, including the shortest.
  task automatic test_length_extremes();
    send_frame(rcrd_pkg::MIN_LENGTH, random_window(), 6'd0);
    send_frame(rcrd_pkg::REPORT_LENGTH - 10'd1, random_window(), 6'd0);
    send_frame(rcrd_pkg::REPORT_LENGTH + 10'd1, random_window(), 6'h3F);
    send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'd0);
    wait_reports_drained(SETTLE_CYCLES);
  endtask

  // Register extremes, with values wider than each register.
  task automatic test_config_extremes();
    write_reg(rcrd_pkg::REG_STICK_OFFSET, 32'hFFFF_FFFF);
    write_reg(rcrd_pkg::REG_STICK_GAIN, 32'h0000_00FF);
    write_reg(rcrd_pkg::REG_CAMERA_GAIN, 32'h0000_0040);
    write_reg(rcrd_pkg::REG_UNUSED, $urandom);
    repeat (2) send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'($urandom));
    wait_reports_drained(SETTLE_CYCLES);
    write_reg(rcrd_pkg::REG_STICK_OFFSET, 32'hFFFF_F000);
    write_reg(rcrd_pkg::REG_STICK_GAIN, 32'd0);
    write_reg(rcrd_pkg::REG_CAMERA_GAIN, 32'd63);
    repeat (2) send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'($urandom));
    wait_reports_drained(SETTLE_CYCLES);
  endtask

  // Mostly well-formed report frames, with other lengths, bad headers and noise mixed in.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int start_bytes;
    int start_reports;
    int pick;
    logic [7:0] b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_bytes = bytes_sent;
    start_reports = reports_due;
    while (bytes_sent - start_bytes < PHASE_BYTES ||
           reports_due - start_reports < PHASE_REPORTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_frame(rcrd_pkg::REPORT_LENGTH, random_window(), 6'($urandom));
      end else if (pick < 74) begin
        if ($urandom_range(0, 24) == 0)
          send_frame(10'($urandom_range(100, int'(MAX_FRAME_LENGTH))), random_window(),
                     6'($urandom));
        else
          send_frame(10'($urandom_range(13, 70)), random_window(), 6'($urandom));
      end else if (pick < 86) begin
        send_bad_header(8'($urandom_range(0, 12)), 6'($urandom));
      end else begin
        // Line noise; a stray sync byte is let through only now and then.
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if (b == rcrd_pkg::SYNC_BYTE && $urandom_range(0, 9) != 0) b = ~b;
          send_byte(b);
        end
      end
      if ($urandom_range(0, 39) == 0) wait_reports_drained(0);
    end
    wait_reports_drained(SETTLE_CYCLES);
  endtask

  initial begin
    reset_model();
    tx_idle_pct = 33;
    rx_idle_pct = 71;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_first_reports();
    test_bad_headers();
    test_length_extremes();
    test_config_extremes();

    write_reg(rcrd_pkg::REG_STICK_OFFSET, $urandom_range(0, 1500));
    write_reg(rcrd_pkg::REG_STICK_GAIN, $urandom_range(1, 63));
    write_reg(rcrd_pkg::REG_CAMERA_GAIN, $urandom_range(1, 63));
    test_random_traffic(33, 71);

    write_reg(rcrd_pkg::REG_STICK_OFFSET, 32'd4095);
    write_reg(rcrd_pkg::REG_STICK_GAIN, 32'd63);
    write_reg(rcrd_pkg::REG_CAMERA_GAIN, 32'd63);
    test_random_traffic(71, 33);

    write_reg(rcrd_pkg::REG_STICK_OFFSET, 32'(rcrd_pkg::STICK_OFFSET_RST));
    write_reg(rcrd_pkg::REG_STICK_GAIN, 32'(rcrd_pkg::STICK_GAIN_RST));
    write_reg(rcrd_pkg::REG_CAMERA_GAIN, 32'(rcrd_pkg::CAMERA_GAIN_RST));
    test_random_traffic(0, 0);

    if (error_count == 0) begin
      $display("tb_remote_control_report_deframer OK");
    end else begin
      $display("tb_remote_control_report_deframer NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rcrd_pkg.sv
hw/rtl/rcrd_front.sv
hw/rtl/rcrd_queue.sv
hw/rtl/rcrd_back.sv
hw/rtl/remote_control_report_deframer.sv
sim/tb_remote_control_report_deframer.sv
